>>> rtl/ftrq_pkg.sv
// Shared constants, register codes and a helper function for the rotation quaternion block.
package ftrq_pkg;

  localparam int OUT_FRAC_BITS_DEF = 30;
  localparam int SQRT_STEPS = 2;
  localparam int DIV_STEPS = 2;

  localparam logic [30:0] RESET_OPP_MARGIN = 31'd1073742;
  localparam logic [30:0] RESET_PAR_LIMIT = 31'd10737418;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef enum logic [0:0] {
    REG_OPP_MARGIN = 1'b0,
    REG_PAR_LIMIT  = 1'b1
  } cfg_reg_t;

  // left shift that brings the largest magnitude into [2^30, 2^31]
  function automatic logic [4:0] shift_count(input logic [31:0] m);
    logic [4:0] k;
    k = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (m[i]) begin
        k = 5'(30 - i);
      end
    end
    return k;
  endfunction

endpackage

>>> rtl/ftrq_prep.sv
// Vector prescale: scale to full range and form the squared length.
module ftrq_prep #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2:0][31:0]  in_vec,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [2:0][32:0]  out_sc,
  output logic [63:0]       out_l2,
  output logic              out_zero,
  output logic [SIDE_W-1:0] out_side
);

  logic [2:0][31:0] mc;
  logic [31:0]      mx;

  logic              v1, v2, v3, v4;
  logic [2:0][31:0]  c1, mc1;
  logic [31:0]       m1;
  logic [SIDE_W-1:0] side1, side2, side3, side4;
  logic [2:0][32:0]  sc2, sc3, sc4;
  logic [2:0][31:0]  msc2;
  logic              zero2, zero3, zero4;
  logic [2:0][63:0]  sq3;
  logic [63:0]       l2_4;
  logic [4:0]        k;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mc[i] = in_vec[i][31] ? 32'(-in_vec[i]) : in_vec[i];
    end
    mx = mc[0];
    if (mc[1] > mx) begin
      mx = mc[1];
    end
    if (mc[2] > mx) begin
      mx = mc[2];
    end
  end

  assign k = ftrq_pkg::shift_count(m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      c1    <= in_vec;
      mc1   <= mc;
      m1    <= mx;
      side1 <= in_side;
      for (int i = 0; i < 3; i++) begin
        sc2[i]  <= {c1[i][31], c1[i]} << k;
        msc2[i] <= mc1[i] << k;
        sq3[i]  <= 64'(msc2[i]) * 64'(msc2[i]);
      end
      zero2 <= (m1 == 32'd0);
      side2 <= side1;
      sc3   <= sc2;
      zero3 <= zero2;
      side3 <= side2;
      l2_4  <= sq3[0] + sq3[1] + sq3[2];
      sc4   <= sc3;
      zero4 <= zero3;
      side4 <= side3;
    end
  end

  assign out_valid = v4;
  assign out_sc    = sc4;
  assign out_l2    = l2_4;
  assign out_zero  = zero4;
  assign out_side  = side4;

endmodule

>>> rtl/ftrq_isqrt.sv
// Pipelined floor square root of a 64-bit word, two result bits per stage.
module ftrq_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_v,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int SPS = ftrq_pkg::SQRT_STEPS;
  localparam int NST = 32 / SPS;

  logic [63:0]       vl_q   [NST];
  logic [35:0]       rm_q   [NST];
  logic [31:0]       rt_q   [NST];
  logic              vld_q  [NST];
  logic [SIDE_W-1:0] side_q [NST];

  for (genvar st = 0; st < NST; st++) begin : g_st
    logic [63:0]       vl_i, vl_c;
    logic [35:0]       rm_i, rm_c;
    logic [31:0]       rt_i, rt_c;
    logic              vld_i;
    logic [SIDE_W-1:0] side_i;

    if (st == 0) begin : g_first
      assign vl_i   = in_v;
      assign rm_i   = '0;
      assign rt_i   = '0;
      assign vld_i  = in_valid;
      assign side_i = in_side;
    end else begin : g_next
      assign vl_i   = vl_q[st-1];
      assign rm_i   = rm_q[st-1];
      assign rt_i   = rt_q[st-1];
      assign vld_i  = vld_q[st-1];
      assign side_i = side_q[st-1];
    end

    always_comb begin
      vl_c = vl_i;
      rm_c = rm_i;
      rt_c = rt_i;
      for (int j = 0; j < SPS; j++) begin
        rm_c = {rm_c[33:0], vl_c[63:62]};
        vl_c = {vl_c[61:0], 2'b00};
        if (rm_c >= {2'b00, rt_c, 2'b01}) begin
          rm_c = rm_c - {2'b00, rt_c, 2'b01};
          rt_c = {rt_c[30:0], 1'b1};
        end else begin
          rt_c = {rt_c[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[st] <= 1'b0;
      end else if (en) begin
        vld_q[st] <= vld_i;
      end
      if (en) begin
        vl_q[st]   <= vl_c;
        rm_q[st]   <= rm_c;
        rt_q[st]   <= rt_c;
        side_q[st] <= side_i;
      end
    end
  end

  assign out_valid = vld_q[NST-1];
  assign out_root  = rt_q[NST-1];
  assign out_side  = side_q[NST-1];

endmodule

>>> rtl/ftrq_div.sv
// Pipelined three-lane rounding divider with a shared divisor, saturating at one.
module ftrq_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2:0][62:0]  in_mag,
  input  logic [2:0]        in_neg,
  input  logic [31:0]       in_d,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [2:0][31:0]  out_q,
  output logic [SIDE_W-1:0] out_side
);

  localparam int DPS = ftrq_pkg::DIV_STEPS;
  localparam int NST = 32 / DPS;

  typedef struct packed {
    logic [31:0] d;
    logic [2:0]  ovf;
    logic [2:0]  neg;
    logic        dz;
  } div_ctl_t;

  logic [2:0][63:0]  nsum;
  logic [2:0]        ovf0;
  div_ctl_t          ctl0;

  logic              ini_vld;
  logic [2:0][31:0]  ini_rem, ini_lo;
  div_ctl_t          ini_ctl;
  logic [SIDE_W-1:0] ini_side;

  logic [2:0][31:0]  rem_q  [NST];
  logic [2:0][31:0]  lo_q   [NST];
  logic [2:0][31:0]  q_q    [NST];
  div_ctl_t          ctl_q  [NST];
  logic              vld_q  [NST];
  logic [SIDE_W-1:0] side_q [NST];

  logic [2:0][31:0]  res;
  logic              fin_vld;
  logic [2:0][31:0]  fin_q;
  logic [SIDE_W-1:0] fin_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsum[i] = {1'b0, in_mag[i]} + {33'd0, in_d[31:1]};
      ovf0[i] = (nsum[i][63:32] >= in_d);
    end
    ctl0.d   = in_d;
    ctl0.ovf = ovf0;
    ctl0.neg = in_neg;
    ctl0.dz  = (in_d == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ini_vld <= 1'b0;
    end else if (en) begin
      ini_vld <= in_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ini_rem[i] <= nsum[i][63:32];
        ini_lo[i]  <= nsum[i][31:0];
      end
      ini_ctl  <= ctl0;
      ini_side <= in_side;
    end
  end

  for (genvar st = 0; st < NST; st++) begin : g_st
    logic [2:0][31:0]  rem_i, lo_i, q_i, rem_c, lo_c, q_c;
    div_ctl_t          ctl_i;
    logic              vld_i;
    logic [SIDE_W-1:0] side_i;
    logic [32:0]       r2;

    if (st == 0) begin : g_first
      assign rem_i  = ini_rem;
      assign lo_i   = ini_lo;
      assign q_i    = '0;
      assign ctl_i  = ini_ctl;
      assign vld_i  = ini_vld;
      assign side_i = ini_side;
    end else begin : g_next
      assign rem_i  = rem_q[st-1];
      assign lo_i   = lo_q[st-1];
      assign q_i    = q_q[st-1];
      assign ctl_i  = ctl_q[st-1];
      assign vld_i  = vld_q[st-1];
      assign side_i = side_q[st-1];
    end

    always_comb begin
      rem_c = rem_i;
      lo_c  = lo_i;
      q_c   = q_i;
      r2    = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < DPS; j++) begin
          r2       = {rem_c[i], lo_c[i][31]};
          lo_c[i]  = {lo_c[i][30:0], 1'b0};
          if (r2 >= {1'b0, ctl_i.d}) begin
            rem_c[i] = 32'(r2 - {1'b0, ctl_i.d});
            q_c[i]   = {q_c[i][30:0], 1'b1};
          end else begin
            rem_c[i] = r2[31:0];
            q_c[i]   = {q_c[i][30:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[st] <= 1'b0;
      end else if (en) begin
        vld_q[st] <= vld_i;
      end
      if (en) begin
        rem_q[st]  <= rem_c;
        lo_q[st]   <= lo_c;
        q_q[st]    <= q_c;
        ctl_q[st]  <= ctl_i;
        side_q[st] <= side_i;
      end
    end
  end

  // saturate at one, zero divisor gives zero, then apply sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ctl_q[NST-1].dz) begin
        res[i] = 32'd0;
      end else if (ctl_q[NST-1].ovf[i] || q_q[NST-1][i] > ftrq_pkg::ONE_Q30) begin
        res[i] = ftrq_pkg::ONE_Q30;
      end else begin
        res[i] = q_q[NST-1][i];
      end
      if (ctl_q[NST-1].neg[i]) begin
        res[i] = 32'(-res[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_vld <= 1'b0;
    end else if (en) begin
      fin_vld <= vld_q[NST-1];
    end
    if (en) begin
      fin_q    <= res;
      fin_side <= side_q[NST-1];
    end
  end

  assign out_valid = fin_vld;
  assign out_q     = fin_q;
  assign out_side  = fin_side;

endmodule

>>> rtl/from_to_rotation_quaternion.sv
// Top level: shortest-arc rotation quaternion between two Q16.16 vectors.
//
// Input channel: in_valid / in_stall with src_x..dst_z, one word per pair of
// vectors. Output channel: out_valid / out_stall with quat_w..quat_z in signed
// Q1.OUT_FRAC_BITS plus the opposite_case and zero_vector flags.
// Configuration: cfg_wr_en writes cfg_data into register cfg_addr
// (0: opposite margin, 1: parallel limit), both Q1.30.
// One word is taken per cycle while the output is not stalled. The path is two
// normalize passes, each a prescale, a 16-stage square root and an 18-stage
// divider, plus a dot/cross section and an output register.
// Reset clears all valid bits and loads the default register values.
// When the receiver stalls a valid output, the whole pipeline holds and
// in_stall rises in the same cycle; bubbles keep flowing otherwise.
module from_to_rotation_quaternion #(
  parameter int OUT_FRAC_BITS = ftrq_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] src_x,
  input  logic signed [31:0] src_y,
  input  logic signed [31:0] src_z,
  input  logic signed [31:0] dst_x,
  input  logic signed [31:0] dst_y,
  input  logic signed [31:0] dst_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic               opposite_case,
  output logic               zero_vector,
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_addr,
  input  logic [30:0]        cfg_data
);

  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam logic [31:0] HALF = (32'd1 << SH) >> 1;

  typedef struct packed {
    logic [2:0][32:0] sc;
    logic             zero;
  } nrm_side_t;

  typedef struct packed {
    logic [2:0][62:0] cr;
    logic [63:0]      vn;
    logic             opp;
    logic             zero;
  } ax_side_t;

  typedef struct packed {
    logic [2:0][32:0] sc;
    logic [2:0][62:0] cr;
    logic             opp;
    logic             zero;
  } rt_side_t;

  typedef struct packed {
    logic [31:0] w;
    logic        opp;
    logic        zero;
  } qt_side_t;

  function automatic logic [31:0] rnd_out(input logic [31:0] v);
    logic [31:0] m;
    logic [31:0] r;
    m = v[31] ? 32'(-v) : v;
    r = (m + HALF) >> SH;
    return v[31] ? 32'(-r) : r;
  endfunction

  logic        en;
  logic [30:0] opp_margin, par_limit;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      opp_margin <= ftrq_pkg::RESET_OPP_MARGIN;
      par_limit  <= ftrq_pkg::RESET_PAR_LIMIT;
    end else if (cfg_wr_en) begin
      case (ftrq_pkg::cfg_reg_t'(cfg_addr))
        ftrq_pkg::REG_OPP_MARGIN: opp_margin <= cfg_data;
        ftrq_pkg::REG_PAR_LIMIT:  par_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // first pass: normalize source and target
  logic             ps_valid, pd_valid;
  logic [2:0][32:0] ps_sc, pd_sc;
  logic [63:0]      ps_l2, pd_l2;
  logic             ps_zero, pd_zero;
  logic             ss_valid, sd_valid;
  logic [31:0]      ss_root, sd_root;
  nrm_side_t        ss_side, sd_side;
  logic [2:0][62:0] ds_mag, dd_mag;
  logic [2:0]       ds_neg, dd_neg;
  logic             va, vb, za, zb;
  logic [2:0][31:0] a, b;

  ftrq_prep #(.SIDE_W(1)) u_prep_src (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .in_vec   ({src_z, src_y, src_x}),
    .in_side  (1'b0),
    .out_valid(ps_valid),
    .out_sc   (ps_sc),
    .out_l2   (ps_l2),
    .out_zero (ps_zero),
    .out_side ()
  );

  ftrq_prep #(.SIDE_W(1)) u_prep_dst (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .in_vec   ({dst_z, dst_y, dst_x}),
    .in_side  (1'b0),
    .out_valid(pd_valid),
    .out_sc   (pd_sc),
    .out_l2   (pd_l2),
    .out_zero (pd_zero),
    .out_side ()
  );

  ftrq_isqrt #(.SIDE_W($bits(nrm_side_t))) u_sqrt_src (
    .clk, .rst, .en,
    .in_valid (ps_valid),
    .in_v     (ps_l2),
    .in_side  ({ps_sc, ps_zero}),
    .out_valid(ss_valid),
    .out_root (ss_root),
    .out_side (ss_side)
  );

  ftrq_isqrt #(.SIDE_W($bits(nrm_side_t))) u_sqrt_dst (
    .clk, .rst, .en,
    .in_valid (pd_valid),
    .in_v     (pd_l2),
    .in_side  ({pd_sc, pd_zero}),
    .out_valid(sd_valid),
    .out_root (sd_root),
    .out_side (sd_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ds_neg[i] = ss_side.sc[i][32];
      dd_neg[i] = sd_side.sc[i][32];
      ds_mag[i] = {1'b0, 32'(ss_side.sc[i][32] ? -ss_side.sc[i] : ss_side.sc[i]), 30'd0};
      dd_mag[i] = {1'b0, 32'(sd_side.sc[i][32] ? -sd_side.sc[i] : sd_side.sc[i]), 30'd0};
    end
  end

  ftrq_div #(.SIDE_W(1)) u_div_src (
    .clk, .rst, .en,
    .in_valid (ss_valid),
    .in_mag   (ds_mag),
    .in_neg   (ds_neg),
    .in_d     (ss_root),
    .in_side  (ss_side.zero),
    .out_valid(va),
    .out_q    (a),
    .out_side (za)
  );

  ftrq_div #(.SIDE_W(1)) u_div_dst (
    .clk, .rst, .en,
    .in_valid (sd_valid),
    .in_mag   (dd_mag),
    .in_neg   (dd_neg),
    .in_d     (sd_root),
    .in_side  (sd_side.zero),
    .out_valid(vb),
    .out_q    (b),
    .out_side (zb)
  );

  // dot, cross and axis selection
  logic                    v1, v2, v3, v4;
  logic signed [2:0][61:0] ab1;
  logic signed [61:0]      m01, m02, m10, m11, m20, m21, sq0, sq1;
  logic [2:0][31:0]        a1, a2, a3;
  logic                    z1, z2, z3, z4;
  logic signed [62:0]      dot2;
  logic [2:0][62:0]        cr2, cr3, cr4;
  logic [61:0]             sqs2;
  logic [62:0]             dmag;
  logic [32:0]             rc;
  logic [31:0]             cmag;
  logic [31:0]             cos3;
  logic                    axx3;
  logic signed [33:0]      thr;
  logic [31:0]             cp;
  logic                    opp4;
  logic [2:0][31:0]        ax4;
  logic [63:0]             vn4;

  always_comb begin
    dmag = dot2[62] ? 63'(-dot2) : 63'(dot2);
    rc   = 33'((dmag + 63'd536870912) >> 30);
    cmag = (rc > {1'b0, ftrq_pkg::ONE_Q30}) ? ftrq_pkg::ONE_Q30 : rc[31:0];
    thr  = $signed({3'b000, opp_margin}) - 34'sd1073741824;
    cp   = 32'($signed({cos3[31], cos3}) + 33'sd1073741824);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= va && vb;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ab1[i] <= $signed(a[i]) * $signed(b[i]);
      end
      m01 <= $signed(a[1]) * $signed(b[2]);
      m02 <= $signed(a[2]) * $signed(b[1]);
      m10 <= $signed(a[2]) * $signed(b[0]);
      m11 <= $signed(a[0]) * $signed(b[2]);
      m20 <= $signed(a[0]) * $signed(b[1]);
      m21 <= $signed(a[1]) * $signed(b[0]);
      sq0 <= $signed(a[0]) * $signed(a[0]);
      sq1 <= $signed(a[1]) * $signed(a[1]);
      a1  <= a;
      z1  <= za || zb;

      dot2   <= 63'($signed(ab1[0])) + 63'($signed(ab1[1])) + 63'($signed(ab1[2]));
      cr2[0] <= 63'(m01) - 63'(m02);
      cr2[1] <= 63'(m10) - 63'(m11);
      cr2[2] <= 63'(m20) - 63'(m21);
      sqs2   <= 62'(sq0 + sq1);
      a2     <= a1;
      z2     <= z1;

      cos3 <= dot2[62] ? 32'(-cmag) : cmag;
      axx3 <= ({1'b0, sqs2} < {2'b00, par_limit, 30'd0});
      cr3  <= cr2;
      a3   <= a2;
      z3   <= z2;

      opp4 <= !z3 && ($signed({{2{cos3[31]}}, cos3}) < thr);
      if (axx3) begin
        ax4 <= {a3[1], 32'(-a3[2]), 32'd0};
      end else begin
        ax4 <= {32'd0, a3[0], 32'(-a3[1])};
      end
      vn4 <= {1'b0, cp, 31'd0};
      cr4 <= cr3;
      z4  <= z3;
    end
  end

  // second pass: fallback axis normalize or half-angle divide
  logic             pa_valid;
  logic [2:0][32:0] pa_sc;
  logic [63:0]      pa_l2;
  ax_side_t         pa_side;
  logic             sr_valid;
  logic [31:0]      sr_root;
  rt_side_t         sr_side;
  logic [2:0][62:0] dq_mag;
  logic [2:0]       dq_neg;
  logic [31:0]      wq;
  logic             dq_valid;
  logic [2:0][31:0] qv;
  qt_side_t         dq_side;

  ftrq_prep #(.SIDE_W($bits(ax_side_t))) u_prep_ax (
    .clk, .rst, .en,
    .in_valid (v4),
    .in_vec   (ax4),
    .in_side  ({cr4, vn4, opp4, z4}),
    .out_valid(pa_valid),
    .out_sc   (pa_sc),
    .out_l2   (pa_l2),
    .out_zero (),
    .out_side (pa_side)
  );

  ftrq_isqrt #(.SIDE_W($bits(rt_side_t))) u_sqrt_q (
    .clk, .rst, .en,
    .in_valid (pa_valid),
    .in_v     (pa_side.opp ? pa_l2 : pa_side.vn),
    .in_side  ({pa_sc, pa_side.cr, pa_side.opp, pa_side.zero}),
    .out_valid(sr_valid),
    .out_root (sr_root),
    .out_side (sr_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sr_side.opp) begin
        dq_neg[i] = sr_side.sc[i][32];
        dq_mag[i] = {1'b0, 32'(sr_side.sc[i][32] ? -sr_side.sc[i] : sr_side.sc[i]), 30'd0};
      end else begin
        dq_neg[i] = sr_side.cr[i][62];
        dq_mag[i] = sr_side.cr[i][62] ? 63'(-sr_side.cr[i]) : sr_side.cr[i];
      end
    end
    wq = sr_side.opp ? 32'd0 : 32'(({1'b0, sr_root} + 33'd1) >> 1);
  end

  ftrq_div #(.SIDE_W($bits(qt_side_t))) u_div_q (
    .clk, .rst, .en,
    .in_valid (sr_valid),
    .in_mag   (dq_mag),
    .in_neg   (dq_neg),
    .in_d     (sr_root),
    .in_side  ({wq, sr_side.opp, sr_side.zero}),
    .out_valid(dq_valid),
    .out_q    (qv),
    .out_side (dq_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dq_valid;
    end
    if (en) begin
      if (dq_side.zero) begin
        quat_w        <= '0;
        quat_x        <= '0;
        quat_y        <= '0;
        quat_z        <= '0;
        opposite_case <= 1'b0;
      end else begin
        quat_w        <= rnd_out(dq_side.w);
        quat_x        <= rnd_out(qv[0]);
        quat_y        <= rnd_out(qv[1]);
        quat_z        <= rnd_out(qv[2]);
        opposite_case <= dq_side.opp;
      end
      zero_vector <= dq_side.zero;
    end
  end

`ifndef SYNTHESIS
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_vector |-> quat_w == 0 && quat_x == 0 && quat_y == 0 &&
      quat_z == 0 && !opposite_case)
    else $error("zero vector word carries nonzero quaternion");

  a_opp_w: assert property (@(posedge clk) disable iff (rst)
    out_valid && opposite_case |-> quat_w == 0)
    else $error("fallback word has nonzero scalar part");

  a_w_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !quat_w[31])
    else $error("scalar part negative");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(opposite_case && zero_vector))
    else $error("fallback and zero flags both set");
`endif

endmodule
